>>> hdl/accel_tilt_pitch_roll_defines.svh
// assertion macros for the tilt block
`ifndef ACCEL_TILT_PITCH_ROLL_DEFINES_SVH
`define ACCEL_TILT_PITCH_ROLL_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define ATPR_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
    else $error("assertion failed");

// implication checked from the next edge on
`define ATPR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/atpr_pkg.sv
// shared constants and the atan table function for the tilt block
`default_nettype none
package atpr_pkg;
  localparam int TABLE_LEN = 24;
  localparam int FRAC_IN = 8;
  localparam int ANGLE_LIMIT = 11520;
  localparam int ACC_W = 26;
  localparam int ANGLE_W = 15;
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_SENSOR_READY = 2'd0;

  // atan(2^-i) in degrees * 65536, rounded
  function automatic logic [22:0] atan_q16(input int i);
    logic [22:0] t;
    unique case (i)
      0: t = 23'd2949120;  1: t = 23'd1740967;  2: t = 23'd919879;
      3: t = 23'd466945;   4: t = 23'd234379;   5: t = 23'd117306;
      6: t = 23'd58666;    7: t = 23'd29335;    8: t = 23'd14668;
      9: t = 23'd7334;     10: t = 23'd3667;    11: t = 23'd1833;
      12: t = 23'd917;     13: t = 23'd458;     14: t = 23'd229;
      15: t = 23'd115;     16: t = 23'd57;      17: t = 23'd29;
      18: t = 23'd14;      19: t = 23'd7;       20: t = 23'd4;
      21: t = 23'd2;       22: t = 23'd1;
      default: t = 23'd0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

>>> hdl/atpr_if.sv
// valid/ready channel interfaces for samples and angles
`default_nettype none
interface atpr_in_if;
  logic valid;
  logic ready;
  logic signed [12:0] accel_x;
  logic signed [12:0] accel_y;
  logic signed [12:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atpr_out_if;
  logic valid;
  logic ready;
  logic signed [14:0] pitch_deg;
  logic signed [14:0] roll_deg;
  logic ok;
  modport source (output valid, pitch_deg, roll_deg, ok, input ready);
  modport sink (input valid, pitch_deg, roll_deg, ok, output ready);
endinterface
`default_nettype wire

>>> hdl/atpr_angle.sv
// pipelined magnitude and cordic vectoring path for one tilt angle
`default_nettype none
module atpr_angle #(
  parameter int SAMPLE_BITS = 13,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic adv,
  input  wire logic signed [SAMPLE_BITS-1:0] opp,
  input  wire logic signed [SAMPLE_BITS-1:0] a,
  input  wire logic signed [SAMPLE_BITS-1:0] b,
  output logic signed [atpr_pkg::ANGLE_W-1:0] angle
);
  localparam int STG = (CORDIC_STAGES > atpr_pkg::TABLE_LEN) ?
                       atpr_pkg::TABLE_LEN : CORDIC_STAGES;
  localparam int SQ_W = 2*SAMPLE_BITS + 1;
  localparam int N_W = SQ_W + 2*atpr_pkg::FRAC_IN;
  localparam int R_W = (N_W + 1) / 2;
  localparam int RSTEPS = R_W;
  localparam int V_W = R_W + 3;
  localparam int AW = atpr_pkg::ACC_W;

  // stage 0: squares
  logic [SQ_W-1:0] sq_r;
  logic signed [SAMPLE_BITS-1:0] opp0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= SQ_W'(unsigned'((2*SAMPLE_BITS)'(a*a))) +
              SQ_W'(unsigned'((2*SAMPLE_BITS)'(b*b)));
      opp0_r <= opp;
    end
  end

  // digit-by-digit square root, one result bit per stage
  logic [N_W-1:0] rem_r [RSTEPS+1];
  logic [R_W-1:0] root_r [RSTEPS+1];
  logic signed [SAMPLE_BITS-1:0] ropp_r [RSTEPS+1];
  always_comb begin
    rem_r[0] = {sq_r, (2*atpr_pkg::FRAC_IN)'(0)};
    root_r[0] = '0;
    ropp_r[0] = opp0_r;
  end
  for (genvar s = 0; s < RSTEPS; s++) begin : g_sqrt
    localparam int K = RSTEPS - 1 - s;
    logic [N_W+1:0] trial;
    logic [N_W+1:0] rm;
    // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
    always_comb begin
      trial = ((N_W+2)'(root_r[s]) << (K+1)) | ((N_W+2)'(1) << (2*K));
      rm = (N_W+2)'(rem_r[s]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rm >= trial) begin
          rem_r[s+1] <= N_W'(rm - trial);
          root_r[s+1] <= root_r[s] | (R_W'(1) << K);
        end else begin
          rem_r[s+1] <= rem_r[s];
          root_r[s+1] <= root_r[s];
        end
        ropp_r[s+1] <= ropp_r[s];
      end
    end
  end

  // cordic vectoring stages
  logic signed [V_W-1:0] xv_r [STG+1];
  logic signed [V_W-1:0] yv_r [STG+1];
  logic signed [AW-1:0] ang_r [STG+1];
  logic zero_r [STG+1];
  always_comb begin
    xv_r[0] = V_W'(signed'({1'b0, root_r[RSTEPS]}));
    yv_r[0] = V_W'(ropp_r[RSTEPS]) <<< atpr_pkg::FRAC_IN;
    ang_r[0] = '0;
    zero_r[0] = (root_r[RSTEPS] == '0) && (ropp_r[RSTEPS] == '0);
  end
  for (genvar i = 0; i < STG; i++) begin : g_cordic
    localparam logic signed [AW-1:0] ATAN = AW'(atpr_pkg::atan_q16(i));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!yv_r[i][V_W-1]) begin
          xv_r[i+1] <= xv_r[i] + (yv_r[i] >>> i);
          yv_r[i+1] <= yv_r[i] - (xv_r[i] >>> i);
          ang_r[i+1] <= ang_r[i] + ATAN;
        end else begin
          xv_r[i+1] <= xv_r[i] - (yv_r[i] >>> i);
          yv_r[i+1] <= yv_r[i] + (xv_r[i] >>> i);
          ang_r[i+1] <= ang_r[i] - ATAN;
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  // round to 7 fraction bits and clamp; a zero vector gives zero
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] lim;
  always_comb begin
    lim = AW'(atpr_pkg::ANGLE_LIMIT);
    rnd = (ang_r[STG] + AW'(256)) >>> 9;
    if (zero_r[STG]) angle = '0;
    else if (rnd > lim) angle = atpr_pkg::ANGLE_W'(lim);
    else if (rnd < -lim) angle = atpr_pkg::ANGLE_W'(-lim);
    else angle = atpr_pkg::ANGLE_W'(rnd);
  end
endmodule
`default_nettype wire

>>> hdl/accel_tilt_pitch_roll.sv
// top level: accelerometer pitch and roll pipeline with apb register
//   channel | dir | handshake          | word
//   in_     | in  | valid/ready        | accel_x, accel_y, accel_z
//   out_    | out | valid/ready        | pitch_deg, roll_deg, ok
//   cfg_    | in  | apb psel/penable   | sensor_ready at byte 0
// one word per cycle while the output is not stalled; pipeline stages:
// square, one stage per root bit, one per cordic stage
// the whole pipe advances when the output stage is empty or taken
// rst_n synchronous: clears valid bits and sensor_ready
`default_nettype none
`include "accel_tilt_pitch_roll_defines.svh"
module accel_tilt_pitch_roll #(
  parameter int SAMPLE_BITS = 13,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  atpr_in_if.sink in_ch,
  atpr_out_if.source out_ch,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [atpr_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int STG = (CORDIC_STAGES > atpr_pkg::TABLE_LEN) ?
                       atpr_pkg::TABLE_LEN : CORDIC_STAGES;
  localparam int N_W = 2*SAMPLE_BITS + 1 + 2*atpr_pkg::FRAC_IN;
  localparam int LAT = 1 + (N_W + 1) / 2 + STG;

  logic ready_r;
  logic adv;
  logic vld_r [LAT];
  logic ok_r [LAT];

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, ready_r};

  always_ff @(posedge clk) begin
    if (!rst_n) ready_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr == atpr_pkg::REG_SENSOR_READY)
      ready_r <= cfg_pwdata[0];
  end

  assign adv = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r[0] <= ready_r;
      for (int k = 1; k < LAT; k++) ok_r[k] <= ok_r[k-1];
    end
  end

  logic signed [SAMPLE_BITS-1:0] sx, sy, sz;
  assign sx = SAMPLE_BITS'(in_ch.accel_x);
  assign sy = SAMPLE_BITS'(in_ch.accel_y);
  assign sz = SAMPLE_BITS'(in_ch.accel_z);

  logic signed [atpr_pkg::ANGLE_W-1:0] pitch, roll;
  atpr_angle #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .adv(adv), .opp(sx), .a(sy), .b(sz), .angle(pitch));
  atpr_angle #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .adv(adv), .opp(sy), .a(sx), .b(sz), .angle(roll));

  assign out_ch.valid = vld_r[LAT-1];
  assign out_ch.ok = ok_r[LAT-1];
  assign out_ch.pitch_deg = ok_r[LAT-1] ? pitch : '0;
  assign out_ch.roll_deg = ok_r[LAT-1] ? roll : '0;

  `ATPR_ASSERT(a_ready_follows, clk, rst_n, in_ch.ready == (!out_ch.valid || out_ch.ready))
  `ATPR_ASSERT(a_zero_not_ok, clk, rst_n,
    !out_ch.valid || out_ch.ok || (out_ch.pitch_deg == '0 && out_ch.roll_deg == '0))
  `ATPR_ASSERT_NEXT(a_hold_stall, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
`default_nettype wire

>>> sim/accel_tilt_pitch_roll_test.sv
// testbench for the accelerometer pitch and roll block: directed table, random samples, apb writes
`default_nettype none
module accel_tilt_pitch_roll_test;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic ok;
  } angles_t;

  typedef struct {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic signed [12:0] z;
    bit known;
    angles_t want;
  } sample_row_t;

  localparam int LATENCY = 39;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [atpr_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  atpr_in_if in_ch();
  atpr_out_if out_ch();

  accel_tilt_pitch_roll i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  bit ready_model;
  angles_t angles_due[$];
  int errors = 0;
  int words_in = 0, words_out = 0, ok_words = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    out_ch.ready = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint n);
    longint r = 0;
    longint b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // atan2(opp, |a,b|) in degrees * 128 via vectoring cordic
  function automatic logic signed [14:0] tilt_of(longint opp, longint a, longint b);
    longint xv, yv, xs, ys, ang;
    xv = root_floor((a * a + b * b) <<< (2 * atpr_pkg::FRAC_IN));
    yv = opp <<< atpr_pkg::FRAC_IN;
    ang = 0;
    if (xv == 0 && yv == 0) return '0;
    for (int i = 0; i < 16; i++) begin
      xs = floor_shr(xv, i);
      ys = floor_shr(yv, i);
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        ang = ang + longint'(atpr_pkg::atan_q16(i));
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        ang = ang - longint'(atpr_pkg::atan_q16(i));
      end
    end
    ang = floor_shr(ang + 256, 9);
    if (ang > atpr_pkg::ANGLE_LIMIT) ang = atpr_pkg::ANGLE_LIMIT;
    if (ang < -atpr_pkg::ANGLE_LIMIT) ang = -atpr_pkg::ANGLE_LIMIT;
    return ang[14:0];
  endfunction

  function automatic angles_t predict_angles(logic signed [12:0] x, logic signed [12:0] y,
                                             logic signed [12:0] z);
    angles_t r;
    r = '0;
    if (ready_model) begin
      r.pitch = tilt_of(x, y, z);
      r.roll = tilt_of(y, x, z);
      r.ok = 1'b1;
    end
    return r;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic apb_write(logic [atpr_pkg::CFG_AW-1:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == atpr_pkg::REG_SENSOR_READY) ready_model = data[0];
  endtask

  task automatic drain();
    while (angles_due.size() != 0) @(posedge clk);
    idle_cycles(LATENCY + 4);
  endtask

  // one sample; the check against a typed value happens on top of the predictor
  task automatic send_sample(logic signed [12:0] x, logic signed [12:0] y,
                             logic signed [12:0] z, bit known, angles_t want);
    angles_t p;
    if ($urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      idle_cycles($urandom_range(0, 12));
    end
    p = predict_angles(x, y, z);
    if (known && p !== want) begin
      $display("%0t table row mismatch x=%0d y=%0d z=%0d expected %h actual %h",
               $time, x, y, z, want, p);
      errors++;
    end
    in_ch.valid <= 1'b1;
    in_ch.accel_x <= x;
    in_ch.accel_y <= y;
    in_ch.accel_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    angles_due.push_back(p);
    words_in++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [12:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return -13'sd4096;
      1: return 13'sd4095;
      2: return 13'(int'($urandom_range(0, 8)) - 4);
      default: return 13'($urandom());
    endcase
  endfunction

  // result side: random stalls plus one long hold-off
  initial begin
    angles_t got, want;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        idle_cycles(300);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        idle_cycles($urandom_range(0, 12));
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.pitch_deg, out_ch.roll_deg, out_ch.ok};
      words_out++;
      if (angles_due.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        errors++;
      end else begin
        want = angles_due.pop_front();
        if (got.ok && got.ok === want.ok) ok_words++;
        if (got.pitch !== want.pitch)
          $display("%0t pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
        if (got.roll !== want.roll)
          $display("%0t roll expected %0d actual %0d", $time, want.roll, got.roll);
        if (got.ok !== want.ok)
          $display("%0t ok expected %0b actual %0b", $time, want.ok, got.ok);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    sample_row_t rows[$];
    angles_t zero_w;
    zero_w = '0;
    rows = '{
      '{13'sd0, 13'sd0, 13'sd0, 1'b1, angles_t'{15'sd0, 15'sd0, 1'b1}},
      '{13'sd0, 13'sd0, 13'sd1000, 1'b1, angles_t'{15'sd0, 15'sd0, 1'b1}},
      '{13'sd0, 13'sd0, -13'sd4096, 1'b1, angles_t'{15'sd0, 15'sd0, 1'b1}},
      '{13'sd4095, 13'sd0, 13'sd0, 1'b0, zero_w},
      '{-13'sd4096, 13'sd0, 13'sd0, 1'b0, zero_w},
      '{13'sd0, 13'sd4095, 13'sd0, 1'b0, zero_w},
      '{13'sd0, -13'sd4096, 13'sd0, 1'b0, zero_w},
      '{13'sd4095, 13'sd4095, 13'sd4095, 1'b0, zero_w},
      '{-13'sd4096, -13'sd4096, -13'sd4096, 1'b0, zero_w},
      '{13'sd1, 13'sd0, 13'sd0, 1'b0, zero_w},
      '{-13'sd1, -13'sd1, 13'sd0, 1'b0, zero_w},
      '{13'sd100, 13'sd100, 13'sd100, 1'b0, zero_w},
      '{13'sd4095, -13'sd4096, 13'sd1, 1'b0, zero_w},
      '{13'sd2730, -13'sd1365, 13'sd2, 1'b0, zero_w},
      '{-13'sd1366, 13'sd2729, -13'sd3, 1'b0, zero_w}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // not ready after reset: zero angles, ok low
    for (int i = 0; i < 4; i++)
      send_sample(rows[i+3].x, rows[i+3].y, rows[i+3].z, 1'b1, zero_w);
    stop_sending();
    drain();
    apb_write(atpr_pkg::REG_SENSOR_READY, 32'hFFFF_FFFF);
    @(posedge clk);
    if (cfg_prdata !== 32'd1) begin
      $display("%0t register readback expected %h actual %h", $time, 32'd1, cfg_prdata);
      errors++;
    end
    foreach (rows[i]) send_sample(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].want);
    stop_sending();
    drain();
    // unmapped register index leaves the setting alone
    apb_write(2'd1, 32'h0);
    apb_write(2'd3, 32'h0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        apb_write(atpr_pkg::REG_SENSOR_READY, 32'h2);
      end else if (ph == 3) begin
        apb_write(atpr_pkg::REG_SENSOR_READY, 32'h1);
        hold_off = 1'b1;
      end
      for (int k = 0; k < 170; k++) begin
        if (ph == 4 && k == 85) begin
          // sender waits until every word has come back
          stop_sending();
          while (angles_due.size() != 0) @(posedge clk);
        end
        send_sample(rand_axis(), rand_axis(), rand_axis(), 1'b0, zero_w);
      end
      stop_sending();
      drain();
    end

    $display("%0d samples sent, %0d angle words checked, %0d with ok set", words_in,
             words_out, ok_words);
    $display("covered sensor not ready and ready, axis extremes, zero vectors, stalls");
    if (errors == 0 && angles_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> accel_tilt_pitch_roll.f
+incdir+hdl
hdl/atpr_pkg.sv
hdl/atpr_if.sv
hdl/atpr_angle.sv
hdl/accel_tilt_pitch_roll.sv
sim/accel_tilt_pitch_roll_test.sv
